// ===== hdl/vrt_pkg.sv =====
// -----------------------------------------------------------------------------
// vrt_pkg
// shared types and constants for the 3d voxel ray traversal unit
// -----------------------------------------------------------------------------
package vrt_pkg;

    localparam int COORD_W = 26;
    localparam int FRAC_W  = 8;
    localparam int KEY_W   = 16;
    localparam int AD_W    = 26;
    localparam int N_W     = 16;
    localparam int PROD_W  = N_W + AD_W;
    localparam int AXES    = 3;
    localparam int AX_W    = 2;
    localparam int CELL    = 256;

    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 48;

    localparam logic [1:0] ST_KEY   = 2'd0;
    localparam logic [1:0] ST_OOB   = 2'd1;
    localparam logic [1:0] ST_SAME  = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    localparam logic [AX_W-1:0] AX_X = 2'd0;
    localparam logic [AX_W-1:0] AX_Y = 2'd1;
    localparam logic [AX_W-1:0] AX_Z = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MA,
        S_MB,
        S_CMP,
        S_STEP,
        S_DECIDE,
        S_TRUNC
    } t_state;

    typedef struct packed {
        logic             en;
        logic [N_W-1:0]   a;
        logic [AD_W-1:0]  b;
    } t_mul_req;

endpackage

// ===== hdl/vrt_mul.sv =====
// -----------------------------------------------------------------------------
// vrt_mul
// shared boundary-distance multiplier with registered product
// -----------------------------------------------------------------------------
module vrt_mul
    import vrt_pkg::*;
(
    input  logic              i_clk,
    input  t_mul_req          i_req,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/voxel_ray_traversal_3d_unit.sv =====
// -----------------------------------------------------------------------------
// voxel_ray_traversal_3d_unit
// 3d dda voxel walk from a ray origin to its end point
// -----------------------------------------------------------------------------
// One ray is taken at a time; o_s_axis_tready is high only while the unit is
// idle. A ray starts in a setup state, then walks step by step: each step
// makes two distance comparisons, each from two products of the single shared
// multiplier (S_MA, S_MB) and a compare (S_CMP), then the step (S_STEP) and
// its decision (S_DECIDE), which waits while the output word is stalled. The
// unit returns to idle after each ray before the next is taken, and a
// truncated ray sends its last word from S_TRUNC. Keys come out in ray order,
// the origin voxel first; the end voxel is never sent. A rejected ray (key out
// of range, or origin and end in one cell) gives one word with zero keys. A
// ray that would give more than MAX_RAY_KEYS-1 keys ends with a truncation
// word that carries the first key not sent.
module voxel_ray_traversal_3d_unit
    import vrt_pkg::*;
#(
    parameter int MAX_RAY_KEYS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // origin_x, origin_y, origin_z, end_x, end_y, end_z, 26 bits each, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // key_x, key_y, key_z
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // status
    output logic [1:0]            o_m_axis_tuser,
    output logic                  o_m_axis_tlast
);

    localparam int CNT_W = (MAX_RAY_KEYS > 2) ? $clog2(MAX_RAY_KEYS) : 1;

    t_state r_state, n_state;

    logic [COORD_W-1:0] r_o [AXES];
    logic [COORD_W-1:0] r_e [AXES];
    logic [KEY_W-1:0]   r_cur [AXES];
    logic [KEY_W-1:0]   r_ke [AXES];
    logic [KEY_W-1:0]   r_pend [AXES];
    logic [N_W-1:0]     r_n [AXES];
    logic [AD_W-1:0]    r_ad [AXES];
    logic [AXES-1:0]    r_up;
    logic [AXES-1:0]    r_inf;
    logic [CNT_W-1:0]   r_cnt;
    logic [AX_W-1:0]    r_a, r_b;
    logic               r_phase;
    logic [AX_W-1:0]    r_dim;
    logic [PROD_W-1:0]  r_p1;

    logic               r_ovalid;
    logic [KEY_W-1:0]   r_okey [AXES];
    logic [1:0]         r_ostat;
    logic               r_olast;

    // setup values
    logic [KEY_W-1:0]   s_ko [AXES];
    logic [KEY_W-1:0]   s_ke [AXES];
    logic [N_W-1:0]     s_n [AXES];
    logic [AD_W-1:0]    s_ad [AXES];
    logic [AXES-1:0]    s_up, s_inf, s_oob_ax, s_same_ax;
    logic [COORD_W:0]   s_d [AXES];
    logic               s_oob, s_same;

    logic               can_load, out_load, lt, hit, beyond, trunc;
    logic [AXES-1:0]    hit_ax, near_ax;
    logic [AX_W-1:0]    n_idx, ad_idx;
    logic [PROD_W-1:0]  prod;
    t_mul_req           mul_req;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            s_d[i]       = {r_e[i][COORD_W-1], r_e[i]} - {r_o[i][COORD_W-1], r_o[i]};
            s_ko[i]      = {~r_o[i][KEY_W+FRAC_W-1], r_o[i][KEY_W+FRAC_W-2:FRAC_W]};
            s_ke[i]      = {~r_e[i][KEY_W+FRAC_W-1], r_e[i][KEY_W+FRAC_W-2:FRAC_W]};
            s_oob_ax[i]  = !((r_o[i][25] == r_o[i][24]) && (r_o[i][24] == r_o[i][23])
                            && (r_e[i][25] == r_e[i][24]) && (r_e[i][24] == r_e[i][23]));
            s_same_ax[i] = (s_ko[i] == s_ke[i]);
            s_inf[i]     = (s_d[i] == '0);
            s_up[i]      = !s_d[i][COORD_W] && !s_inf[i];
            s_ad[i]      = s_d[i][COORD_W] ? AD_W'(-s_d[i]) : AD_W'(s_d[i]);
            s_n[i]       = s_up[i] ? N_W'(CELL) - N_W'(r_o[i][FRAC_W-1:0])
                                   : N_W'(r_o[i][FRAC_W-1:0]);
        end
        s_oob  = |s_oob_ax;
        s_same = &s_same_ax;
    end

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            hit_ax[i]  = (r_cur[i] == r_ke[i]);
            near_ax[i] = !r_inf[i] && (AD_W'(r_n[i]) <= r_ad[i]);
        end
        hit    = &hit_ax;
        beyond = !(|near_ax);
        trunc  = (r_cnt == CNT_W'(MAX_RAY_KEYS - 1));
    end

    // infinite t is never less than anything
    always_comb begin
        if (r_inf[r_a]) begin
            lt = 1'b0;
        end else if (r_inf[r_b]) begin
            lt = 1'b1;
        end else begin
            lt = (r_p1 < prod);
        end
    end

    assign can_load = !r_ovalid || i_m_axis_tready;

    // one read address per operand array each cycle
    assign n_idx  = (r_state == S_MA) ? r_a : r_b;
    assign ad_idx = (r_state == S_MA) ? r_b : r_a;

    always_comb begin
        mul_req.en = (r_state == S_MA) || (r_state == S_MB);
        mul_req.a  = r_n[n_idx];
        mul_req.b  = r_ad[ad_idx];
    end

    vrt_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) n_state = S_SETUP;
            end
            S_SETUP: begin
                if (s_oob || s_same) begin
                    if (can_load) n_state = S_IDLE;
                end else begin
                    n_state = S_MA;
                end
            end
            S_MA:  n_state = S_MB;
            S_MB:  n_state = S_CMP;
            S_CMP: n_state = r_phase ? S_STEP : S_MA;
            S_STEP: n_state = S_DECIDE;
            S_DECIDE: begin
                if (can_load) begin
                    if (hit || beyond) n_state = S_IDLE;
                    else if (trunc)    n_state = S_TRUNC;
                    else               n_state = S_MA;
                end
            end
            S_TRUNC: begin
                if (can_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        o_m_axis_tvalid = r_ovalid;
        o_m_axis_tdata  = {r_okey[2], r_okey[1], r_okey[0]};
        o_m_axis_tuser  = r_ostat;
        o_m_axis_tlast  = r_olast;
        case (r_state)
            S_SETUP:           out_load = can_load && (s_oob || s_same);
            S_DECIDE, S_TRUNC: out_load = can_load;
            default:           out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                for (int i = 0; i < AXES; i++) begin
                    r_o[i] <= i_s_axis_tdata[i*COORD_W +: COORD_W];
                    r_e[i] <= i_s_axis_tdata[(i+AXES)*COORD_W +: COORD_W];
                end
            end
            S_SETUP: begin
                for (int i = 0; i < AXES; i++) begin
                    r_cur[i]  <= s_ko[i];
                    r_pend[i] <= s_ko[i];
                    r_ke[i]   <= s_ke[i];
                    r_n[i]    <= s_n[i];
                    r_ad[i]   <= s_ad[i];
                end
                r_up    <= s_up;
                r_inf   <= s_inf;
                r_cnt   <= CNT_W'(1);
                r_a     <= AX_X;
                r_b     <= AX_Y;
                r_phase <= 1'b0;
                // a waiting word from the previous ray must stay intact
                if ((s_oob || s_same) && can_load) begin
                    for (int i = 0; i < AXES; i++) r_okey[i] <= '0;
                    r_ostat <= s_oob ? ST_OOB : ST_SAME;
                    r_olast <= 1'b1;
                end
            end
            S_MB: r_p1 <= prod;
            S_CMP: begin
                if (!r_phase) begin
                    r_a     <= lt ? AX_X : AX_Y;
                    r_b     <= AX_Z;
                    r_phase <= 1'b1;
                end else begin
                    r_dim <= lt ? r_a : AX_Z;
                end
            end
            S_STEP: begin
                r_cur[r_dim] <= r_cur[r_dim] + (r_up[r_dim] ? KEY_W'(1) : '1);
                r_n[r_dim]   <= r_n[r_dim] + N_W'(CELL);
            end
            S_DECIDE: begin
                if (can_load) begin
                    for (int i = 0; i < AXES; i++) begin
                        r_okey[i] <= r_pend[i];
                        r_pend[i] <= r_cur[i];
                    end
                    r_ostat <= ST_KEY;
                    r_olast <= hit || beyond;
                    r_cnt   <= r_cnt + CNT_W'(1);
                    r_a     <= AX_X;
                    r_b     <= AX_Y;
                    r_phase <= 1'b0;
                end
            end
            S_TRUNC: begin
                if (can_load) begin
                    for (int i = 0; i < AXES; i++) r_okey[i] <= r_cur[i];
                    r_ostat <= ST_TRUNC;
                    r_olast <= 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/vrt_checker.sv =====
// -----------------------------------------------------------------------------
// vrt_checker
// port-level checks for the voxel ray traversal unit
// -----------------------------------------------------------------------------
module vrt_checker
    import vrt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]            o_m_axis_tuser,
    input logic                  o_m_axis_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word changed under stall");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // every status other than a plain key closes the ray
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_KEY |-> o_m_axis_tlast)
        else $error("status word without last");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_OOB || o_m_axis_tuser == ST_SAME)
        |-> o_m_axis_tdata == '0)
        else $error("rejected ray carries keys");

    // a ray is taken only when idle, so no ray is taken right after another
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ray taken while busy");

endmodule

bind voxel_ray_traversal_3d_unit vrt_checker u_vrt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
